// ===== design/i64alu_pkg.sv =====
// ----------------------------------------------------------------------------
// i64alu_pkg
// Types and constants shared by the 64-bit integer ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package i64alu_pkg;

  localparam int unsigned XLEN     = 64;
  localparam int unsigned HLEN     = 32;
  localparam int unsigned FUNC_W   = 5;
  localparam int unsigned SHAMT_W  = 6;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_NEG     = 5'd0,
    FN_NOT     = 5'd1,
    FN_INC     = 5'd2,
    FN_DEC     = 5'd3,
    FN_ADD     = 5'd4,
    FN_SUB     = 5'd5,
    FN_MUL     = 5'd6,
    FN_SDIV    = 5'd7,
    FN_SMOD    = 5'd8,
    FN_UDIV    = 5'd9,
    FN_UMOD    = 5'd10,
    FN_UDIV32  = 5'd11,
    FN_UMOD32  = 5'd12,
    FN_AND     = 5'd13,
    FN_OR      = 5'd14,
    FN_XOR     = 5'd15,
    FN_SLL     = 5'd16,
    FN_SRL     = 5'd17,
    FN_SRA     = 5'd18,
    FN_SCMP    = 5'd19,
    FN_UCMP    = 5'd20,
    FN_TRUNC32 = 5'd21,
    FN_ZEXT32  = 5'd22,
    FN_SEXT32  = 5'd23
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  localparam logic [XLEN-1:0] SIGN_BIT = {1'b1, {(XLEN-1){1'b0}}};

  // Control and early result carried alongside the divider stages
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              neg_q;
    logic              neg_r;
    status_e           status;
    logic [XLEN-1:0]   res;
  } ctl_t;

endpackage

`default_nettype wire

// ===== design/i64alu_req_if.sv =====
// ----------------------------------------------------------------------------
// i64alu_req_if
// Request channel: function code, operands and shift amount.
// ----------------------------------------------------------------------------
`default_nettype none

interface i64alu_req_if;
  logic                                valid;
  logic                                ready;
  logic [i64alu_pkg::FUNC_W-1:0]       func;
  logic signed [i64alu_pkg::XLEN-1:0]  operand_a;
  logic signed [i64alu_pkg::XLEN-1:0]  operand_b;
  logic [i64alu_pkg::SHAMT_W-1:0]      shift_amount;

  modport source (output valid, func, operand_a, operand_b, shift_amount, input ready);
  modport sink   (input valid, func, operand_a, operand_b, shift_amount, output ready);
endinterface

`default_nettype wire

// ===== design/i64alu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// i64alu_rsp_if
// Response channel: 64-bit result and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface i64alu_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [i64alu_pkg::XLEN-1:0]  result;
  logic [i64alu_pkg::STATUS_W-1:0]     status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

`default_nettype wire

// ===== design/int64_alu_with_divide_traps.sv =====
// ----------------------------------------------------------------------------
// int64_alu_with_divide_traps
// Pipelined 64-bit integer ALU with divide-by-zero and overflow traps.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per transaction (func, operand_a, operand_b,
//   shift_amount); rsp_o returns one transaction per request, in order, with
//   the 64-bit result and a status (ok, divide by zero, signed overflow).
//   Every operation takes the same path: one entry stage, 64 restoring
//   divider stages (one quotient bit each), and one output stage, whatever
//   the function code. Throughput is one transaction per cycle while rsp_o
//   is not stalled; the divider chain sets the depth. The 64x64 multiply is
//   split into three 32x32 partial products, registered in the entry stage
//   and summed in the first divider stage.
//   When rsp_o is stalled the whole pipeline holds and req_i.ready drops;
//   nothing is lost or repeated. Reset clears all stage valid bits; no
//   transaction is in flight afterward.
// ----------------------------------------------------------------------------
`default_nettype none

module int64_alu_with_divide_traps (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  i64alu_req_if.sink        req_i,
  i64alu_rsp_if.source      rsp_o
);
  import i64alu_pkg::*;

  localparam int unsigned NSTEP = XLEN;
  localparam int unsigned LAST  = NSTEP + 1;

  logic en;

  logic            valid_q [0:LAST];
  ctl_t            ctl_q   [0:LAST];
  ctl_t            ctl_d   [0:LAST];
  logic [XLEN-1:0] rem_q   [0:NSTEP];
  logic [XLEN-1:0] quo_q   [0:NSTEP];
  logic [XLEN-1:0] dvs_q   [0:NSTEP-1];
  logic [XLEN-1:0] rem_d   [0:NSTEP];
  logic [XLEN-1:0] quo_d   [0:NSTEP];
  logic [XLEN-1:0] dvs_d   [0:NSTEP-1];

  logic [2*HLEN-1:0] p_ll_q;
  logic [2*HLEN-1:0] p_ll_d;
  logic [HLEN-1:0]   p_lh_q, p_hl_q;
  logic [HLEN-1:0]   p_lh_d, p_hl_d;

  assign en          = !valid_q[LAST] || rsp_o.ready;
  assign req_i.ready = en;

  // Entry stage: simple ops, traps, divider operands, multiply partials
  logic [XLEN-1:0] a, b, res0, mag_a, mag_b;
  logic [HLEN-1:0] a_lo, b_lo;
  logic            na, nb, b_zero, b32_zero, ovf;
  func_e           fn;

  always_comb begin
    a        = req_i.operand_a;
    b        = req_i.operand_b;
    fn       = func_e'(req_i.func);
    a_lo     = a[HLEN-1:0];
    b_lo     = b[HLEN-1:0];
    na       = a[XLEN-1];
    nb       = b[XLEN-1];
    mag_a    = na ? (~a + 1'b1) : a;
    mag_b    = nb ? (~b + 1'b1) : b;
    b_zero   = (b == '0);
    b32_zero = (b_lo == '0);
    ovf      = (a == SIGN_BIT) && (b == '1);
    p_ll_d   = {{HLEN{1'b0}}, a_lo} * {{HLEN{1'b0}}, b_lo};
    // Only the low half of the cross products reaches the low 64 bits
    p_lh_d   = a_lo * b[XLEN-1:HLEN];
    p_hl_d   = a[XLEN-1:HLEN] * b_lo;

    res0      = '0;
    ctl_d[0]  = '0;
    rem_d[0]  = '0;
    quo_d[0]  = a;
    dvs_d[0]  = b;
    case (fn)
      FN_NEG:     res0 = ~a + 1'b1;
      FN_NOT:     res0 = ~a;
      FN_INC:     res0 = a + 1'b1;
      FN_DEC:     res0 = a - 1'b1;
      FN_ADD:     res0 = a + b;
      FN_SUB:     res0 = a - b;
      FN_AND:     res0 = a & b;
      FN_OR:      res0 = a | b;
      FN_XOR:     res0 = a ^ b;
      FN_SLL:     res0 = a << req_i.shift_amount;
      FN_SRL:     res0 = a >> req_i.shift_amount;
      FN_SRA:     res0 = $signed(a) >>> req_i.shift_amount;
      FN_SCMP:    res0 = ($signed(a) == $signed(b)) ? '0 :
                         (($signed(a) < $signed(b)) ? '1 : XLEN'(1));
      FN_UCMP:    res0 = (a == b) ? '0 : ((a < b) ? '1 : XLEN'(1));
      FN_TRUNC32,
      FN_ZEXT32:  res0 = {{HLEN{1'b0}}, a_lo};
      FN_SEXT32:  res0 = {{HLEN{a_lo[HLEN-1]}}, a_lo};
      FN_SDIV, FN_SMOD: begin
        quo_d[0] = mag_a;
        dvs_d[0] = mag_b;
        if (b_zero)   ctl_d[0].status = ST_DIV_ZERO;
        else if (ovf) ctl_d[0].status = ST_OVERFLOW;
      end
      FN_UDIV, FN_UMOD: begin
        if (b_zero) ctl_d[0].status = ST_DIV_ZERO;
      end
      FN_UDIV32, FN_UMOD32: begin
        quo_d[0] = {{HLEN{1'b0}}, a_lo};
        dvs_d[0] = {{HLEN{1'b0}}, b_lo};
        if (b32_zero) ctl_d[0].status = ST_DIV_ZERO;
      end
      default: res0 = '0;
    endcase
    ctl_d[0].func  = req_i.func;
    ctl_d[0].neg_q = na ^ nb;
    ctl_d[0].neg_r = na;
    ctl_d[0].res   = res0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ll_q <= p_ll_d;
      p_lh_q <= p_lh_d;
      p_hl_q <= p_hl_d;
    end
  end

  // Divider chain; the multiply sum folds into the first step
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    i64alu_div_step u_step (
      .rem_i (rem_q[k]),
      .quo_i (quo_q[k]),
      .dvs_i (dvs_q[k]),
      .rem_o (rem_d[k+1]),
      .quo_o (quo_d[k+1])
    );
    if (k < NSTEP - 1) begin : g_dvs
      assign dvs_d[k+1] = dvs_q[k];
    end
    if (k == 0) begin : g_mul
      logic [HLEN-1:0] cross_sum;
      assign cross_sum = p_lh_q + p_hl_q;
      always_comb begin
        ctl_d[k+1] = ctl_q[k];
        if (func_e'(ctl_q[k].func) == FN_MUL) begin
          ctl_d[k+1].res = p_ll_q + {cross_sum, {HLEN{1'b0}}};
        end
      end
    end else begin : g_pass
      assign ctl_d[k+1] = ctl_q[k];
    end
  end

  // Output stage: sign fix, result select and zeroing of trapped results
  logic [XLEN-1:0] qf, rf;
  assign qf = quo_q[NSTEP];
  assign rf = rem_q[NSTEP];

  always_comb begin
    ctl_d[LAST] = ctl_q[NSTEP];
    case (func_e'(ctl_q[NSTEP].func))
      FN_SDIV:   ctl_d[LAST].res = ctl_q[NSTEP].neg_q ? (~qf + 1'b1) : qf;
      FN_SMOD:   ctl_d[LAST].res = ctl_q[NSTEP].neg_r ? (~rf + 1'b1) : rf;
      FN_UDIV,
      FN_UDIV32: ctl_d[LAST].res = qf;
      FN_UMOD,
      FN_UMOD32: ctl_d[LAST].res = rf;
      default:   ctl_d[LAST].res = ctl_q[NSTEP].res;
    endcase
    if (ctl_q[NSTEP].status != ST_OK) begin
      ctl_d[LAST].res = '0;
    end
  end

  for (genvar s = 0; s <= LAST; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en) begin
        valid_q[s] <= (s == 0) ? req_i.valid : valid_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ctl_q[s] <= ctl_d[s];
      end
    end
  end

  for (genvar s = 0; s <= NSTEP; s++) begin : g_data
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
    if (s < NSTEP) begin : g_dvs_reg
      always_ff @(posedge clk_i) begin
        if (en) begin
          dvs_q[s] <= dvs_d[s];
        end
      end
    end
  end

  assign rsp_o.valid  = valid_q[LAST];
  assign rsp_o.result = ctl_q[LAST].res;
  assign rsp_o.status = ctl_q[LAST].status;

  // A trapped operation always returns zero
  a_trap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |-> (rsp_o.result == '0))
    else $error("trap with nonzero result");

  // Compares give -1, 0 or 1
  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && ((func_e'(ctl_q[LAST].func) == FN_SCMP) ||
                    (func_e'(ctl_q[LAST].func) == FN_UCMP))
    |-> ((rsp_o.result == '0) || (rsp_o.result == '1) ||
         (rsp_o.result == XLEN'(1))))
    else $error("compare result out of range");

  // Only divide codes can trap
  a_trap_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != ST_OK) |->
    ((func_e'(ctl_q[LAST].func) == FN_SDIV) || (func_e'(ctl_q[LAST].func) == FN_SMOD) ||
     (func_e'(ctl_q[LAST].func) == FN_UDIV) || (func_e'(ctl_q[LAST].func) == FN_UMOD) ||
     (func_e'(ctl_q[LAST].func) == FN_UDIV32) ||
     (func_e'(ctl_q[LAST].func) == FN_UMOD32)))
    else $error("trap on a non-divide operation");

endmodule

`default_nettype wire

// ===== design/i64alu_div_step.sv =====
// ----------------------------------------------------------------------------
// i64alu_div_step
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module i64alu_div_step (
  input  wire logic [i64alu_pkg::XLEN-1:0] rem_i,
  input  wire logic [i64alu_pkg::XLEN-1:0] quo_i,
  input  wire logic [i64alu_pkg::XLEN-1:0] dvs_i,
  output logic      [i64alu_pkg::XLEN-1:0] rem_o,
  output logic      [i64alu_pkg::XLEN-1:0] quo_o
);
  import i64alu_pkg::*;

  logic [XLEN:0] trial;
  logic [XLEN:0] diff;

  assign trial = {rem_i, quo_i[XLEN-1]};
  assign diff  = trial - {1'b0, dvs_i};

  always_comb begin
    if (!diff[XLEN]) begin
      rem_o = diff[XLEN-1:0];
      quo_o = {quo_i[XLEN-2:0], 1'b1};
    end else begin
      rem_o = trial[XLEN-1:0];
      quo_o = {quo_i[XLEN-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire
